>>> rtl/fpa_pkg.sv
// Shared constants, operation codes and the status struct of the fixed-point ALU.
package fpa_pkg;

  localparam int DEFAULT_WORD_BITS     = 32;
  localparam int DEFAULT_FRACTION_BITS = 8;

  localparam int FUNC_W  = 4;
  localparam int FIELD_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_ADD = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_INC = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_DEC = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_INT = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_MIN = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_MAX = 4'd8;

  typedef struct packed {
    logic is_div;
    logic neg;
    logic less;
    logic equal;
    logic greater;
    logic div_zero;
    logic ovf;
  } flags_t;

endpackage

>>> rtl/fpa_in_if.sv
// Input channel of the fixed-point ALU: operation code and two raw operands.
interface fpa_in_if
  import fpa_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [FIELD_W-1:0] operand_a;
  logic signed [FIELD_W-1:0] operand_b;

  modport source (output valid, output func, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input func, input operand_a, input operand_b,
                output ready);

endinterface

>>> rtl/fpa_out_if.sv
// Output channel of the fixed-point ALU: result word and status flags.
interface fpa_out_if
  import fpa_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] value;
  logic                      is_less;
  logic                      is_equal;
  logic                      is_greater;
  logic                      divide_by_zero;
  logic                      overflow;

  modport source (output valid, output value, output is_less, output is_equal,
                  output is_greater, output divide_by_zero, output overflow,
                  input ready);
  modport sink (input valid, input value, input is_less, input is_equal,
                input is_greater, input divide_by_zero, input overflow,
                output ready);

endinterface

>>> rtl/fpa_front.sv
// Two front stages: decode, simple operations, multiply and divider setup.
module fpa_front
  import fpa_pkg::*;
#(
  parameter int WORD_BITS     = DEFAULT_WORD_BITS,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS,
  localparam int QUO_BITS = WORD_BITS + FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [FUNC_W-1:0]           up_func,
  input  logic [FIELD_W-1:0]          up_a,
  input  logic [FIELD_W-1:0]          up_b,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic signed [WORD_BITS-1:0] dn_value,
  output logic [WORD_BITS-1:0]        dn_rem,
  output logic [QUO_BITS-1:0]         dn_nq,
  output logic [WORD_BITS-1:0]        dn_den,
  output flags_t                      dn_flags
);

  localparam int PW = 2 * WORD_BITS;
  localparam int MW = PW - FRACTION_BITS;
  localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS:0]   ONE  = (WORD_BITS+1)'(1);
  localparam logic [PW-1:0] HALF    = {{(PW-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);
  localparam logic [PW-1:0] HALF_P1 = HALF + {{(PW-1){1'b0}}, 1'b1};
  localparam logic [MW-1:0] LIM     = MW'({1'b1, {(WORD_BITS-1){1'b0}}});

  logic signed [WORD_BITS-1:0] a_in;
  logic signed [WORD_BITS-1:0] b_in;
  logic signed [WORD_BITS:0]   a_ext;
  logic signed [WORD_BITS:0]   b_ext;
  logic signed [WORD_BITS:0]   sum_ext;
  logic                        arith;
  logic signed [WORD_BITS-1:0] val_next;
  logic                        ovf_next;
  logic                        lt;
  logic                        gt;
  logic [WORD_BITS-1:0]        mag_a_next;
  logic [WORD_BITS-1:0]        mag_b_next;

  logic                        a_valid;
  logic                        a_open;
  logic [FUNC_W-1:0]           a_func;
  logic signed [WORD_BITS-1:0] a_value;
  logic signed [PW-1:0]        a_prod;
  logic [WORD_BITS-1:0]        a_mag_a;
  logic [WORD_BITS-1:0]        a_mag_b;
  flags_t                      a_flags;

  logic                        b_open;
  logic                        prod_neg;
  logic [PW-1:0]               rsum;
  logic [MW-1:0]               mmag;
  logic                        mul_ovf;
  logic signed [WORD_BITS-1:0] mul_val;
  logic signed [WORD_BITS-1:0] b_value_next;
  flags_t                      b_flags_next;

  assign a_in  = signed'(up_a[WORD_BITS-1:0]);
  assign b_in  = signed'(up_b[WORD_BITS-1:0]);
  assign a_ext = (WORD_BITS+1)'(a_in);
  assign b_ext = (WORD_BITS+1)'(b_in);
  assign lt    = a_in < b_in;
  assign gt    = a_in > b_in;
  assign mag_a_next = a_in[WORD_BITS-1] ? (~up_a[WORD_BITS-1:0] + 1'b1) : up_a[WORD_BITS-1:0];
  assign mag_b_next = b_in[WORD_BITS-1] ? (~up_b[WORD_BITS-1:0] + 1'b1) : up_b[WORD_BITS-1:0];

  always_comb begin
    sum_ext  = '0;
    arith    = 1'b0;
    val_next = '0;
    ovf_next = 1'b0;
    unique case (up_func)
      FUNC_ADD: begin
        sum_ext = a_ext + b_ext;
        arith   = 1'b1;
      end
      FUNC_SUB: begin
        sum_ext = a_ext - b_ext;
        arith   = 1'b1;
      end
      FUNC_INC: begin
        sum_ext = a_ext + ONE;
        arith   = 1'b1;
      end
      FUNC_DEC: begin
        sum_ext = a_ext - ONE;
        arith   = 1'b1;
      end
      FUNC_INT: val_next = a_in >>> FRACTION_BITS;
      FUNC_MIN: val_next = lt ? a_in : b_in;
      FUNC_MAX: val_next = gt ? a_in : b_in;
      default: begin
      end
    endcase
    if (arith) begin
      if (sum_ext[WORD_BITS] != sum_ext[WORD_BITS-1]) begin
        ovf_next = 1'b1;
        val_next = sum_ext[WORD_BITS] ? SMIN : SMAX;
      end else begin
        val_next = sum_ext[WORD_BITS-1:0];
      end
    end
  end

  assign b_open   = !dn_valid || dn_ready;
  assign a_open   = !a_valid || b_open;
  assign up_ready = a_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_open) begin
      a_valid <= up_valid;
    end
    if (up_valid && a_open) begin
      a_func           <= up_func;
      a_value          <= val_next;
      a_prod           <= PW'(a_in) * PW'(b_in);
      a_mag_a          <= mag_a_next;
      a_mag_b          <= mag_b_next;
      a_flags.is_div   <= (up_func == FUNC_DIV) && (b_in != '0);
      a_flags.neg      <= a_in[WORD_BITS-1] ^ b_in[WORD_BITS-1];
      a_flags.less     <= lt;
      a_flags.equal    <= a_in == b_in;
      a_flags.greater  <= gt;
      a_flags.div_zero <= (up_func == FUNC_DIV) && (b_in == '0);
      a_flags.ovf      <= ovf_next;
    end
  end

  // Multiply rounding: for a negative product, |p| + half equals ~p + half + 1.
  always_comb begin
    prod_neg = a_prod[PW-1];
    rsum     = prod_neg ? (~unsigned'(a_prod) + HALF_P1) : (unsigned'(a_prod) + HALF);
    mmag     = rsum[PW-1:FRACTION_BITS];
    mul_ovf  = prod_neg ? (mmag > LIM) : (mmag >= LIM);
    if (mul_ovf) begin
      mul_val = prod_neg ? SMIN : SMAX;
    end else begin
      mul_val = prod_neg ? (~mmag[WORD_BITS-1:0] + 1'b1) : mmag[WORD_BITS-1:0];
    end
    b_value_next = a_value;
    b_flags_next = a_flags;
    if (a_func == FUNC_MUL) begin
      b_value_next     = mul_val;
      b_flags_next.ovf = mul_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (b_open) begin
      dn_valid <= a_valid;
    end
    if (a_valid && b_open) begin
      dn_value <= b_value_next;
      dn_flags <= b_flags_next;
      dn_rem   <= '0;
      dn_nq    <= {a_mag_a, {FRACTION_BITS{1'b0}}};
      dn_den   <= a_mag_b;
    end
  end

endmodule

>>> rtl/fpa_div_cell.sv
// One cell of the divider row: a single restoring step that yields one quotient bit.
module fpa_div_cell
  import fpa_pkg::*;
#(
  parameter int WORD_BITS = DEFAULT_WORD_BITS,
  parameter int QUO_BITS  = DEFAULT_WORD_BITS + DEFAULT_FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic signed [WORD_BITS-1:0] up_value,
  input  logic [WORD_BITS-1:0]        up_rem,
  input  logic [QUO_BITS-1:0]         up_nq,
  input  logic [WORD_BITS-1:0]        up_den,
  input  flags_t                      up_flags,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic signed [WORD_BITS-1:0] dn_value,
  output logic [WORD_BITS-1:0]        dn_rem,
  output logic [QUO_BITS-1:0]         dn_nq,
  output logic [WORD_BITS-1:0]        dn_den,
  output flags_t                      dn_flags
);

  logic [WORD_BITS-1:0] trial;
  logic                 fits;
  logic [WORD_BITS-1:0] rem_next;
  logic [QUO_BITS-1:0]  nq_next;

  // For a nonzero divisor the remainder stays below it, so its top bit is always clear.
  assign trial    = {up_rem[WORD_BITS-2:0], up_nq[QUO_BITS-1]};
  assign fits     = trial >= up_den;
  assign rem_next = fits ? (trial - up_den) : trial;
  assign nq_next  = {up_nq[QUO_BITS-2:0], fits};
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      dn_value <= up_value;
      dn_rem   <= rem_next;
      dn_nq    <= nq_next;
      dn_den   <= up_den;
      dn_flags <= up_flags;
    end
  end

endmodule

>>> rtl/fpa_back.sv
// Output stage: quotient rounding and saturation, then the output register.
module fpa_back
  import fpa_pkg::*;
#(
  parameter int WORD_BITS = DEFAULT_WORD_BITS,
  parameter int QUO_BITS  = DEFAULT_WORD_BITS + DEFAULT_FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic signed [WORD_BITS-1:0] up_value,
  input  logic [WORD_BITS-1:0]        up_rem,
  input  logic [QUO_BITS-1:0]         up_nq,
  input  logic [WORD_BITS-1:0]        up_den,
  input  flags_t                      up_flags,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic signed [FIELD_W-1:0]   dn_value,
  output flags_t                      dn_flags
);

  localparam int RW = QUO_BITS + 1;
  localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [RW-1:0] LIM = RW'({1'b1, {(WORD_BITS-1){1'b0}}});

  logic                        round_up;
  logic [RW-1:0]               qr;
  logic                        div_ovf;
  logic signed [WORD_BITS-1:0] div_val;
  logic signed [WORD_BITS-1:0] value_next;
  flags_t                      flags_next;

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  always_comb begin
    round_up = {up_rem, 1'b0} >= {1'b0, up_den};
    qr       = RW'(up_nq) + RW'(round_up);
    div_ovf  = up_flags.neg ? (qr > LIM) : (qr >= LIM);
    if (div_ovf) begin
      div_val = up_flags.neg ? SMIN : SMAX;
    end else begin
      div_val = up_flags.neg ? (~qr[WORD_BITS-1:0] + 1'b1) : qr[WORD_BITS-1:0];
    end
    value_next = up_value;
    flags_next = up_flags;
    if (up_flags.is_div) begin
      value_next     = div_val;
      flags_next.ovf = div_ovf;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      dn_value <= FIELD_W'(value_next);
      dn_flags <= flags_next;
    end
  end

endmodule

>>> rtl/fixed_point_alu.sv
// Top level of the signed fixed-point ALU: front stages, divider cell row, output stage.
// Default format is Q24.8; the divider row settles one quotient bit per cell.
// Throughput is one word per cycle unless result.ready stalls the pipeline.
// Every stage takes a new word whenever it is empty or its successor moves on.
// Synchronous reset empties the whole pipeline; no other state is kept.
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int WORD_BITS     = DEFAULT_WORD_BITS,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input logic      clk,
  input logic      rst,
  fpa_in_if.sink   operands,
  fpa_out_if.source result
);

  localparam int QUO_BITS = WORD_BITS + FRACTION_BITS;
  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0]   OUT_MAX  = FIELD_W'(WORD_MAX);
  localparam logic signed [FIELD_W-1:0]   OUT_MIN  = FIELD_W'(WORD_MIN);

  logic                        chain_valid [QUO_BITS+1];
  logic                        chain_ready [QUO_BITS+1];
  logic signed [WORD_BITS-1:0] chain_value [QUO_BITS+1];
  logic [WORD_BITS-1:0]        chain_rem   [QUO_BITS+1];
  logic [QUO_BITS-1:0]         chain_nq    [QUO_BITS+1];
  logic [WORD_BITS-1:0]        chain_den   [QUO_BITS+1];
  flags_t                      chain_flags [QUO_BITS+1];
  flags_t                      out_flags;

  fpa_front #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (operands.valid),
    .up_ready (operands.ready),
    .up_func  (operands.func),
    .up_a     (operands.operand_a),
    .up_b     (operands.operand_b),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_value (chain_value[0]),
    .dn_rem   (chain_rem[0]),
    .dn_nq    (chain_nq[0]),
    .dn_den   (chain_den[0]),
    .dn_flags (chain_flags[0])
  );

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    fpa_div_cell #(
      .WORD_BITS (WORD_BITS),
      .QUO_BITS  (QUO_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_value (chain_value[i]),
      .up_rem   (chain_rem[i]),
      .up_nq    (chain_nq[i]),
      .up_den   (chain_den[i]),
      .up_flags (chain_flags[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_value (chain_value[i+1]),
      .dn_rem   (chain_rem[i+1]),
      .dn_nq    (chain_nq[i+1]),
      .dn_den   (chain_den[i+1]),
      .dn_flags (chain_flags[i+1])
    );
  end

  fpa_back #(
    .WORD_BITS (WORD_BITS),
    .QUO_BITS  (QUO_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[QUO_BITS]),
    .up_ready (chain_ready[QUO_BITS]),
    .up_value (chain_value[QUO_BITS]),
    .up_rem   (chain_rem[QUO_BITS]),
    .up_nq    (chain_nq[QUO_BITS]),
    .up_den   (chain_den[QUO_BITS]),
    .up_flags (chain_flags[QUO_BITS]),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .dn_value (result.value),
    .dn_flags (out_flags)
  );

  assign result.is_less        = out_flags.less;
  assign result.is_equal       = out_flags.equal;
  assign result.is_greater     = out_flags.greater;
  assign result.divide_by_zero = out_flags.div_zero;
  assign result.overflow       = out_flags.ovf;

  a_div_zero_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_by_zero |-> result.value == '0 && !result.overflow)
    else $error("divide by zero word carries a nonzero value or overflow");

  a_compare_onehot: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $onehot({result.is_less, result.is_equal, result.is_greater}))
    else $error("comparison flags are not exactly one hot");

  a_overflow_saturates: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflow |-> result.value == OUT_MAX || result.value == OUT_MIN)
    else $error("overflow word is not saturated to the range limits");

endmodule
